>>> src/ble_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list engine package
// Shared sizes, codes and the structs that pass between the list engine's
// sequencer, its word store and its compare unit.
// ----------------------------------------------------------------------------
package ble_pkg;

  // Capacity of the list in words.
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // Fixed field widths of the item channels.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned ST_W    = 2;

  // Width at which an item index is compared against the occupancy.
  localparam int unsigned IDXC_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_SORT   = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // One write port and one read port of the word store, used every cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    word_t a;
    word_t b;
  } alu_in_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } alu_res_t;

endpackage

>>> src/ble_store.sv
// ----------------------------------------------------------------------------
// Bounded list word store
// Holds the list entries: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ble_store (
  input  logic                clk_i,
  input  ble_pkg::store_req_t req_i,
  output ble_pkg::word_t      rd_data_o
);
  import ble_pkg::*;

  word_t mem_q [DEPTH];
  word_t rd_data_q;

  // Entries carry no reset; only entries below the occupancy are ever read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/ble_alu.sv
// ----------------------------------------------------------------------------
// Bounded list compare unit
// Equality and signed greater-than of two words, shared by find and sort.
// ----------------------------------------------------------------------------
module ble_alu (
  input  ble_pkg::alu_in_t  op_i,
  output ble_pkg::alu_res_t res_o
);
  import ble_pkg::*;

  assign res_o.eq = (op_i.a == op_i.b);
  assign res_o.gt = (op_i.a > op_i.b);

endmodule

>>> src/ble_seq.sv
// ----------------------------------------------------------------------------
// Bounded list sequencer
// Decodes each item, steps through the store one entry per cycle and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module ble_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ble_pkg::OP_W-1:0]            opcode_i,
  input  logic [ble_pkg::IDX_W-1:0]           index_i,
  input  ble_pkg::word_t                      value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ble_pkg::word_t                      data_o,
  output logic                                found_o,
  output logic [ble_pkg::POS_W-1:0]           position_o,
  output logic [ble_pkg::COUNT_W-1:0]         count_o,
  output logic [ble_pkg::ST_W-1:0]            status_o,
  output ble_pkg::store_req_t                 mem_req_o,
  input  ble_pkg::word_t                      mem_rdata_i,
  output ble_pkg::alu_in_t                    alu_in_o,
  input  ble_pkg::alu_res_t                   alu_res_i
);
  import ble_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_REMOVE,
    S_FIND,
    S_SORT_LOAD,
    S_SORT_CMP,
    S_SORT_STORE,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   p_q, p_d;
  logic [CNT_W-1:0]   j_q, j_d;
  word_t              a_q, a_d;
  word_t              val_q, val_d;
  word_t              res_data_q, res_data_d;
  logic               res_found_q, res_found_d;
  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  word_t              out_data_q, out_data_d;
  logic               out_found_q, out_found_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  status_e            out_status_q, out_status_d;

  logic               accept;
  logic               full, empty;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W:0]     cnt_x, p_inc1, p_inc2, j_inc1;
  logic [IDXC_W-1:0]  idx_c, cnt_c;
  logic               in_range, idx_has_next;
  store_req_t         req;

  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i && (state_q == S_IDLE);
  assign full         = (cnt_q == CNT_W'(DEPTH));
  assign empty        = (cnt_q == '0);
  assign cnt_dec      = cnt_q - CNT_W'(1);
  assign cnt_x        = {1'b0, cnt_q};
  assign p_inc1       = {1'b0, p_q} + (CNT_W + 1)'(1);
  assign p_inc2       = {1'b0, p_q} + (CNT_W + 1)'(2);
  assign j_inc1       = {1'b0, j_q} + (CNT_W + 1)'(1);
  assign idx_c        = IDXC_W'(index_i);
  assign cnt_c        = IDXC_W'(cnt_q);
  assign in_range     = (idx_c < cnt_c);
  assign idx_has_next = ({1'b0, idx_c} + (IDXC_W + 1)'(1)) < {1'b0, cnt_c};

  // Find compares against the searched word, sort against the held minimum.
  assign alu_in_o.a = (state_q == S_FIND) ? val_q : a_q;
  assign alu_in_o.b = mem_rdata_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    p_d          = p_q;
    j_d          = j_q;
    a_d          = a_q;
    val_d        = val_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_found_d  = out_found_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    req.we       = 1'b0;
    req.waddr    = p_q[ADDR_W-1:0];
    req.wdata    = a_q;
    req.raddr    = p_q[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d        = value_i;
          res_data_d   = '0;
          res_found_d  = 1'b0;
          res_pos_d    = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          unique case (op_e'(opcode_i))
            OP_PUSH: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                req.we    = 1'b1;
                req.waddr = cnt_q[ADDR_W-1:0];
                req.wdata = value_i;
                cnt_d     = cnt_q + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                cnt_d     = cnt_dec;
                req.raddr = cnt_dec[ADDR_W-1:0];
                state_d   = S_DATA;
              end
            end
            OP_READ: begin
              if (!in_range) begin
                res_status_d = ST_RANGE;
              end else begin
                req.raddr = ADDR_W'(index_i);
                state_d   = S_DATA;
              end
            end
            OP_WRITE: begin
              if (!in_range) begin
                res_status_d = ST_RANGE;
              end else begin
                req.we    = 1'b1;
                req.waddr = ADDR_W'(index_i);
                req.wdata = value_i;
              end
            end
            OP_REMOVE: begin
              if (!in_range) begin
                res_status_d = ST_RANGE;
              end else begin
                p_d = CNT_W'(index_i);
                if (idx_has_next) begin
                  req.raddr = ADDR_W'(idx_c + IDXC_W'(1));
                  state_d   = S_REMOVE;
                end else begin
                  cnt_d = cnt_dec;
                end
              end
            end
            OP_FIND: begin
              p_d       = '0;
              req.raddr = '0;
              if (!empty) begin
                state_d = S_FIND;
              end
            end
            OP_SORT: begin
              p_d       = '0;
              req.raddr = '0;
              if (cnt_q >= CNT_W'(2)) begin
                state_d = S_SORT_LOAD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_DATA: begin
        res_data_d = mem_rdata_i;
        state_d    = S_DONE;
      end

      // Entry p+1 is on the read port; it moves down into entry p.
      S_REMOVE: begin
        req.we    = 1'b1;
        req.waddr = p_q[ADDR_W-1:0];
        req.wdata = mem_rdata_i;
        p_d       = CNT_W'(p_inc1);
        if (p_inc2 < cnt_x) begin
          req.raddr = ADDR_W'(p_inc2);
        end else begin
          cnt_d   = cnt_dec;
          state_d = S_DONE;
        end
      end

      S_FIND: begin
        if (alu_res_i.eq) begin
          res_found_d = 1'b1;
          res_pos_d   = POS_W'(p_q);
          state_d     = S_DONE;
        end else if (p_inc1 < cnt_x) begin
          req.raddr = ADDR_W'(p_inc1);
          p_d       = CNT_W'(p_inc1);
        end else begin
          state_d = S_DONE;
        end
      end

      // Entry p is loaded into a register that keeps the smaller word while later entries stream past it.
      S_SORT_LOAD: begin
        a_d       = mem_rdata_i;
        j_d       = CNT_W'(p_inc1);
        req.raddr = ADDR_W'(p_inc1);
        state_d   = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        if (alu_res_i.gt) begin
          req.we    = 1'b1;
          req.waddr = j_q[ADDR_W-1:0];
          req.wdata = a_q;
          a_d       = mem_rdata_i;
        end
        if (j_inc1 < cnt_x) begin
          req.raddr = ADDR_W'(j_inc1);
          j_d       = CNT_W'(j_inc1);
        end else begin
          state_d = S_SORT_STORE;
        end
      end

      S_SORT_STORE: begin
        req.we    = 1'b1;
        req.waddr = p_q[ADDR_W-1:0];
        req.wdata = a_q;
        req.raddr = ADDR_W'(p_inc1);
        p_d       = CNT_W'(p_inc1);
        if (p_inc2 < cnt_x) begin
          state_d = S_SORT_LOAD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_found_d  = res_found_q;
          out_pos_d    = res_pos_q;
          out_count_d  = COUNT_W'(cnt_q);
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      p_q          <= '0;
      j_q          <= '0;
      a_q          <= '0;
      val_q        <= '0;
      res_data_q   <= '0;
      res_found_q  <= 1'b0;
      res_pos_q    <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_found_q  <= 1'b0;
      out_pos_q    <= '0;
      out_count_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      p_q          <= p_d;
      j_q          <= j_d;
      a_q          <= a_d;
      val_q        <= val_d;
      res_data_q   <= res_data_d;
      res_found_q  <= res_found_d;
      res_pos_q    <= res_pos_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_found_q  <= out_found_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= out_count_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign found_o     = out_found_q;
  assign position_o  = out_pos_q;
  assign count_o     = out_count_q;
  assign status_o    = out_status_q;

endmodule

>>> src/bounded_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded list engine
// A list of up to DEPTH signed words with push, pop, indexed read, write and
// remove, first-match find and an in-place ascending exchange sort.
// ----------------------------------------------------------------------------
// Usage: the request channel (in_valid_i / in_stall_o) carries one item with
// an opcode, an index and a value. An item is taken when valid is high and
// stall is low; stall stays high while the sequencer works on an item, so
// only one item is in the sequencer at a time. Every item yields exactly one
// result item on the response channel (out_valid_o / out_stall_i).
// Work per item, with n entries held:
//   push, write and any flagged request: the result is set up on acceptance
//   pop and read: one store read, then the result
//   find: entries scanned from 0 to a match or the end, one entry compared per cycle
//   remove at index k: entries k + 1 to n - 1 move down, one entry moved per cycle
//   sort: per position, a load, one compare per cycle with each later entry, a store
// The rate is set by the single read port of the entry store, which feeds
// one entry per cycle to the shared compare unit.
// A finished result sits in an output register. A new item is taken while it
// waits, and a receiver stall only holds the next result at its last step.
// Reset empties the list and drops any pending result; entries are not
// cleared, since only entries below the count are ever read.
module bounded_list_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ble_pkg::OP_W-1:0]     opcode_i,
  input  logic [ble_pkg::IDX_W-1:0]    index_i,
  input  ble_pkg::word_t               value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ble_pkg::word_t               data_o,
  output logic                         found_o,
  output logic [ble_pkg::POS_W-1:0]    position_o,
  output logic [ble_pkg::COUNT_W-1:0]  count_o,
  output logic [ble_pkg::ST_W-1:0]     status_o
);
  import ble_pkg::*;

  // The sequencer drives one write and one read address every cycle.
  store_req_t mem_req;
  word_t      mem_rdata;

  // Shared compare unit: equality for find, signed order for sort.
  alu_in_t    alu_in;
  alu_res_t   alu_res;

  ble_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .count_o     (count_o),
    .status_o    (status_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .alu_in_o    (alu_in),
    .alu_res_i   (alu_res)
  );

  ble_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rdata)
  );

  ble_alu u_alu (
    .op_i  (alu_in),
    .res_o (alu_res)
  );

endmodule
